FILE: rtl/mi4_pkg.sv
// mi4_pkg: shared widths, command and status types, and cofactor term tables
// for the 4x4 matrix inverse. Used by mi4_ctrl, mi4_datapath and matrix4_inverse.
`timescale 1ns / 1ps

package mi4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NELEM     = 16;
    localparam int IDXW      = 4;
    localparam int DATAW     = 32;
    // cofactor register width: exact 3x3 minors of 32-bit values fit in 97 bits
    localparam int CW        = 100;
    // accumulator and determinant width: exact determinant fits in 134 bits
    localparam int AW        = 136;
    // numerator magnitude width: cofactor magnitude shifted by 2*FRAC_BITS
    localparam int NW        = CW + 2 * FRAC_BITS;
    localparam int LIMBS     = 4;
    localparam int CXW       = LIMBS * DATAW;
    localparam int PW        = 2 * (DATAW + 1);
    localparam int DIVSTEPS  = DATAW;
    localparam logic [DATAW-1:0] ONE_VAL  = DATAW'(1) << FRAC_BITS;
    localparam logic [DATAW-1:0] NEG_LIM  = {1'b1, {(DATAW-1){1'b0}}};
    localparam logic [DATAW-1:0] POS_LIM  = {1'b0, {(DATAW-1){1'b1}}};

    typedef enum logic [1:0] {
        B_Q,
        B_M1LO,
        B_M1HI,
        B_LIMB
    } bsel_t;

    typedef struct packed {
        logic              st_we;
        logic [IDXW-1:0]   st_addr;
        logic [IDXW-1:0]   cof_addr;
        logic              cof_we;
        logic              ld_a;
        logic              ld_c;
        logic              ld_m1;
        logic              mul;
        bsel_t             bsel;
        logic [1:0]        limb;
        logic              acc_clr;
        logic              acc_add;
        logic              acc_neg;
        logic [1:0]        acc_sh;
        logic              ld_det;
        logic              div_init;
        logic              div_step;
        logic              rnd;
        logic              emit;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic singular;
        logic out_free;
    } stat_t;

    // index i of the three kept lines, skipping line gap
    function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] gap);
        return (i < gap) ? i : i + 2'd1;
    endfunction

    // column choice of term t (six permutations of a 3x3 determinant)
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] p);
        logic [1:0] r;
        case (t)
            3'd0:    r = p;
            3'd1:    r = (p == 2'd0) ? 2'd0 : ((p == 2'd1) ? 2'd2 : 2'd1);
            3'd2:    r = (p == 2'd0) ? 2'd1 : ((p == 2'd1) ? 2'd0 : 2'd2);
            3'd3:    r = (p == 2'd0) ? 2'd1 : ((p == 2'd1) ? 2'd2 : 2'd0);
            3'd4:    r = (p == 2'd0) ? 2'd2 : ((p == 2'd1) ? 2'd0 : 2'd1);
            default: r = (p == 2'd0) ? 2'd2 : ((p == 2'd1) ? 2'd1 : 2'd0);
        endcase
        return r;
    endfunction

    // store address of factor p of term t of cofactor k (row k[3:2], col k[1:0]);
    // the minor drops row k[1:0] and column k[3:2]
    function automatic logic [IDXW-1:0] term_addr(input logic [IDXW-1:0] k,
                                                  input logic [2:0] t,
                                                  input logic [1:0] p);
        logic [1:0] row;
        logic [1:0] col;
        row = skip_idx(p, k[1:0]);
        col = skip_idx(perm_col(t, p), k[3:2]);
        return {row, col};
    endfunction

    // term sign: odd permutation xor cofactor checkerboard sign
    function automatic logic term_neg(input logic [IDXW-1:0] k, input logic [2:0] t);
        logic odd;
        odd = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
        return odd ^ k[2] ^ k[0];
    endfunction

endpackage

FILE: rtl/mi4_ram.sv
// mi4_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mi4_ctrl.sv
// mi4_ctrl: sequencer for load, cofactor, determinant, divide and emit phases.
// Depends on mi4_pkg.
`timescale 1ns / 1ps

module mi4_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           go,
    output logic           in_ready,
    output mi4_pkg::cmd_t  cmd,
    input  mi4_pkg::stat_t stat
);
    import mi4_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CT0, S_CT1, S_CT2, S_CT3, S_CT4, S_CT5, S_CT6,
        S_CWR,
        S_DT0, S_DT1, S_DT2, S_DT3, S_DT4, S_DT5, S_DT6,
        S_DFIN,
        S_O0, S_O1, S_O2,
        S_DIV,
        S_RND,
        S_EMIT
    } state_t;

    state_t          state_reg;
    logic [IDXW-1:0] k_reg;
    logic [2:0]      t_reg;
    logic [4:0]      n_reg;
    logic            sg;

    assign in_ready = (state_reg == S_IDLE);
    assign sg       = term_neg(k_reg, t_reg);

    always_comb
    begin
        cmd          = '0;
        cmd.bsel     = B_Q;
        cmd.st_we    = in_valid && (state_reg == S_IDLE);
        cmd.cof_addr = k_reg;
        case (state_reg)
            // hold the accumulator at zero so the first cofactor starts clean
            S_IDLE: cmd.acc_clr = 1'b1;
            S_CT0: cmd.st_addr = term_addr(k_reg, t_reg, 2'd0);
            S_CT1:
            begin
                cmd.st_addr = term_addr(k_reg, t_reg, 2'd1);
                cmd.ld_a    = 1'b1;
            end
            S_CT2:
            begin
                cmd.st_addr = term_addr(k_reg, t_reg, 2'd2);
                cmd.mul     = 1'b1;
                cmd.bsel    = B_Q;
            end
            S_CT3:
            begin
                cmd.ld_m1 = 1'b1;
                cmd.ld_a  = 1'b1;
            end
            S_CT4:
            begin
                cmd.mul  = 1'b1;
                cmd.bsel = B_M1LO;
            end
            S_CT5:
            begin
                cmd.acc_add = 1'b1;
                cmd.acc_neg = sg;
                cmd.acc_sh  = 2'd0;
                cmd.mul     = 1'b1;
                cmd.bsel    = B_M1HI;
            end
            S_CT6:
            begin
                cmd.acc_add = 1'b1;
                cmd.acc_neg = sg;
                cmd.acc_sh  = 2'd1;
            end
            S_CWR:
            begin
                cmd.cof_we  = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            S_DT0:
            begin
                cmd.st_addr  = {2'b00, k_reg[1:0]};
                cmd.cof_addr = {k_reg[1:0], 2'b00};
            end
            S_DT1:
            begin
                cmd.ld_a = 1'b1;
                cmd.ld_c = 1'b1;
            end
            S_DT2:
            begin
                cmd.mul  = 1'b1;
                cmd.bsel = B_LIMB;
                cmd.limb = 2'd0;
            end
            S_DT3, S_DT4, S_DT5:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul     = 1'b1;
                cmd.bsel    = B_LIMB;
                if (state_reg == S_DT3)
                begin
                    cmd.acc_sh = 2'd0;
                    cmd.limb   = 2'd1;
                end
                else if (state_reg == S_DT4)
                begin
                    cmd.acc_sh = 2'd1;
                    cmd.limb   = 2'd2;
                end
                else
                begin
                    cmd.acc_sh = 2'd2;
                    cmd.limb   = 2'd3;
                end
            end
            S_DT6:
            begin
                cmd.acc_add = 1'b1;
                cmd.acc_sh  = 2'd3;
            end
            S_DFIN:   cmd.ld_det   = 1'b1;
            S_O1:     cmd.ld_c     = 1'b1;
            S_O2:     cmd.div_init = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_RND:    cmd.rnd      = 1'b1;
            S_EMIT:
            begin
                cmd.emit = stat.out_free;
                cmd.last = (k_reg == IDXW'(NELEM - 1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            t_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && go)
                    begin
                        state_reg <= S_CT0;
                        k_reg     <= '0;
                        t_reg     <= '0;
                    end
                end
                S_CT0: state_reg <= S_CT1;
                S_CT1: state_reg <= S_CT2;
                S_CT2: state_reg <= S_CT3;
                S_CT3: state_reg <= S_CT4;
                S_CT4: state_reg <= S_CT5;
                S_CT5: state_reg <= S_CT6;
                S_CT6:
                begin
                    if (t_reg == 3'd5)
                    begin
                        state_reg <= S_CWR;
                    end
                    else
                    begin
                        t_reg     <= t_reg + 3'd1;
                        state_reg <= S_CT0;
                    end
                end
                S_CWR:
                begin
                    t_reg <= '0;
                    if (k_reg == IDXW'(NELEM - 1))
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DT0;
                    end
                    else
                    begin
                        k_reg     <= k_reg + IDXW'(1);
                        state_reg <= S_CT0;
                    end
                end
                S_DT0: state_reg <= S_DT1;
                S_DT1: state_reg <= S_DT2;
                S_DT2: state_reg <= S_DT3;
                S_DT3: state_reg <= S_DT4;
                S_DT4: state_reg <= S_DT5;
                S_DT5: state_reg <= S_DT6;
                S_DT6:
                begin
                    if (k_reg == IDXW'(3))
                    begin
                        k_reg     <= '0;
                        state_reg <= S_DFIN;
                    end
                    else
                    begin
                        k_reg     <= k_reg + IDXW'(1);
                        state_reg <= S_DT0;
                    end
                end
                S_DFIN: state_reg <= S_O0;
                S_O0:   state_reg <= stat.singular ? S_EMIT : S_O1;
                S_O1:   state_reg <= S_O2;
                S_O2:
                begin
                    n_reg     <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    n_reg <= n_reg + 5'd1;
                    if (n_reg == 5'(DIVSTEPS - 1))
                    begin
                        state_reg <= S_RND;
                    end
                end
                S_RND: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (stat.out_free)
                    begin
                        if (k_reg == IDXW'(NELEM - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + IDXW'(1);
                            state_reg <= S_O0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/mi4_datapath.sv
// mi4_datapath: matrix store, shared 33x33 multiplier, accumulator, cofactor
// RAM, restoring divider and output register. Depends on mi4_pkg, mi4_ram.
`timescale 1ns / 1ps

module mi4_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mi4_pkg::cmd_t                 cmd,
    output mi4_pkg::stat_t                stat,
    input  logic [mi4_pkg::IDXW-1:0]      element_index,
    input  logic signed [mi4_pkg::DATAW-1:0] element_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mi4_pkg::IDXW-1:0]      result_index,
    output logic signed [mi4_pkg::DATAW-1:0] result_value,
    output logic                          singular,
    output logic                          saturated,
    output logic                          last_result
);
    import mi4_pkg::*;

    // matrix store; valid bits give the reset-to-zero view
    logic [DATAW-1:0]  st_rdata;
    logic [NELEM-1:0]  vld_reg;
    logic              vld_q_reg;
    logic signed [DATAW-1:0] sq;

    // cofactor store
    logic [CW-1:0]     cof_rdata;

    logic signed [DATAW-1:0] a_reg;
    logic signed [CW-1:0]    c_reg;
    logic [2*DATAW-1:0]      m1_reg;
    logic signed [PW-1:0]    p_reg;
    logic signed [AW-1:0]    acc_reg;

    logic              sing_reg;
    logic              dneg_reg;
    logic [AW-1:0]     dmag_reg;

    logic [AW-1:0]     rem_reg;
    logic [DATAW-1:0]  nlo_reg;
    logic [DATAW-1:0]  q_reg;
    logic              neg_reg;
    logic              big_reg;
    logic [DATAW-1:0]  res_reg;
    logic              sat_reg;

    logic              out_valid_reg;
    logic [IDXW-1:0]   out_index_reg;
    logic [DATAW-1:0]  out_value_reg;
    logic              out_sing_reg;
    logic              out_sat_reg;
    logic              out_last_reg;

    logic signed [DATAW:0]   mul_a;
    logic signed [DATAW:0]   mul_b;
    logic [CXW-1:0]          c_ext;
    logic [DATAW-1:0]        limb;
    logic signed [AW-1:0]    p_ext;
    logic signed [AW-1:0]    p_sh;
    logic [CW-1:0]           cmag;
    logic [NW-1:0]           nfull;
    logic [AW:0]             trial;
    logic                    ge;
    logic [AW:0]             trial_sub;
    logic                    up;
    logic [DATAW:0]          qr;
    logic                    bigf;
    logic [DATAW-1:0]        ident;

    function automatic logic out_idx_diag(input logic [IDXW-1:0] k);
        return k[3:2] == k[1:0];
    endfunction

    mi4_ram #(.WIDTH(DATAW), .DEPTH(NELEM)) u_store (
        .clk   (clk),
        .we    (cmd.st_we),
        .waddr (element_index),
        .wdata (element_value),
        .raddr (cmd.st_addr),
        .rdata (st_rdata)
    );

    mi4_ram #(.WIDTH(CW), .DEPTH(NELEM)) u_cof (
        .clk   (clk),
        .we    (cmd.cof_we),
        .waddr (cmd.cof_addr),
        .wdata (acc_reg[CW-1:0]),
        .raddr (cmd.cof_addr),
        .rdata (cof_rdata)
    );

    assign sq = vld_q_reg ? $signed(st_rdata) : '0;

    // multiplier operand selection
    assign c_ext = {{(CXW-CW){c_reg[CW-1]}}, c_reg};
    assign limb  = c_ext[DATAW*cmd.limb +: DATAW];
    assign mul_a = {a_reg[DATAW-1], a_reg};

    always_comb
    begin
        case (cmd.bsel)
            B_Q:     mul_b = {sq[DATAW-1], sq};
            B_M1LO:  mul_b = {1'b0, m1_reg[DATAW-1:0]};
            B_M1HI:  mul_b = {m1_reg[2*DATAW-1], m1_reg[2*DATAW-1:DATAW]};
            B_LIMB:  mul_b = (cmd.limb == 2'd3) ? {limb[DATAW-1], limb} : {1'b0, limb};
            default: mul_b = '0;
        endcase
    end

    // accumulator addend: product shifted by whole limbs, wraps modulo 2^AW
    assign p_ext = {{(AW-PW){p_reg[PW-1]}}, p_reg};
    always_comb
    begin
        case (cmd.acc_sh)
            2'd0:    p_sh = p_ext;
            2'd1:    p_sh = p_ext <<< DATAW;
            2'd2:    p_sh = p_ext <<< (2 * DATAW);
            default: p_sh = p_ext <<< (3 * DATAW);
        endcase
    end

    // divider
    assign cmag      = c_reg[CW-1] ? CW'(-c_reg) : CW'(c_reg);
    assign nfull     = NW'(cmag) << (2 * FRAC_BITS);
    assign trial     = {rem_reg, nlo_reg[DATAW-1]};
    assign ge        = trial >= {1'b0, dmag_reg};
    assign trial_sub = trial - {1'b0, dmag_reg};
    assign up        = {rem_reg, 1'b0} >= {1'b0, dmag_reg};
    assign qr        = {1'b0, q_reg} + (DATAW+1)'(up);
    assign bigf      = big_reg | qr[DATAW];
    assign ident     = (out_idx_diag(cmd.cof_addr)) ? ONE_VAL : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.ld_a)
        begin
            a_reg <= sq;
        end
        if (cmd.ld_c)
        begin
            c_reg <= $signed(cof_rdata);
        end
        if (cmd.ld_m1)
        begin
            m1_reg <= p_reg[2*DATAW-1:0];
        end
        if (cmd.mul)
        begin
            p_reg <= mul_a * mul_b;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= cmd.acc_neg ? acc_reg - p_sh : acc_reg + p_sh;
        end
        if (cmd.ld_det)
        begin
            dneg_reg <= acc_reg[AW-1];
            dmag_reg <= acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        end
        if (cmd.div_init)
        begin
            neg_reg <= c_reg[CW-1] ^ dneg_reg;
            big_reg <= AW'(nfull[NW-1:DATAW]) >= dmag_reg;
            rem_reg <= AW'(nfull[NW-1:DATAW]);
            nlo_reg <= nfull[DATAW-1:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? trial_sub[AW-1:0] : trial[AW-1:0];
            nlo_reg <= {nlo_reg[DATAW-2:0], 1'b0};
            q_reg   <= {q_reg[DATAW-2:0], ge};
        end
        if (cmd.rnd)
        begin
            if (neg_reg)
            begin
                if (bigf || (qr[DATAW-1:0] > NEG_LIM))
                begin
                    res_reg <= NEG_LIM;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    res_reg <= -qr[DATAW-1:0];
                    sat_reg <= 1'b0;
                end
            end
            else
            begin
                if (bigf || qr[DATAW-1])
                begin
                    res_reg <= POS_LIM;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    res_reg <= qr[DATAW-1:0];
                    sat_reg <= 1'b0;
                end
            end
        end
        if (cmd.emit)
        begin
            out_index_reg <= cmd.cof_addr;
            out_value_reg <= sing_reg ? ident : res_reg;
            out_sing_reg  <= sing_reg;
            out_sat_reg   <= sing_reg ? 1'b0 : sat_reg;
            out_last_reg  <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            vld_q_reg     <= 1'b0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.st_we)
            begin
                vld_reg[element_index] <= 1'b1;
            end
            vld_q_reg <= vld_reg[cmd.st_addr];
            if (cmd.ld_det)
            begin
                sing_reg <= (acc_reg == '0);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.singular = sing_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign result_index = out_index_reg;
    assign result_value = $signed(out_value_reg);
    assign singular     = out_sing_reg;
    assign saturated    = out_sat_reg;
    assign last_result  = out_last_reg;

endmodule

FILE: rtl/matrix4_inverse.sv
// matrix4_inverse: top level of the fixed-point 4x4 matrix inverse.
// Depends on mi4_pkg, mi4_ctrl, mi4_datapath (and mi4_ram through it).
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready  | element_index, element_value, go
//  output  | out       | out_valid / out_ready| result_index, result_value, singular,
//          |           |                      | saturated, last_result
//
// An item without go is stored. An item with go is stored, then the sixteen
// cofactors are formed (six 3-factor terms each, one term at a time on the
// single 33x33 multiplier), then the determinant, and then each result in
// the one-bit-a-cycle divider. A singular matrix skips division.
// Reset clears the store to zero through per-entry valid bits; no clearing pass.
// A stalled output holds its item; the next result waits for the register to free.

module matrix4_inverse (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mi4_pkg::IDXW-1:0]            element_index,
    input  logic signed [mi4_pkg::DATAW-1:0]    element_value,
    input  logic                                go,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mi4_pkg::IDXW-1:0]            result_index,
    output logic signed [mi4_pkg::DATAW-1:0]    result_value,
    output logic                                singular,
    output logic                                saturated,
    output logic                                last_result
);
    import mi4_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: accepts items while idle, steps the datapath through each phase
    mi4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .go       (go),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // arithmetic, stores and the output register
    mi4_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .element_index (element_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_index  (result_index),
        .result_value  (result_value),
        .singular      (singular),
        .saturated     (saturated),
        .last_result   (last_result)
    );

endmodule
